### design/wavefolder_sample_assert.svh
// ----------------------------------------------------------------------------
// wavefolder assertion macros
// shared concurrent assertion forms for the wavefolder design files
// ----------------------------------------------------------------------------
`ifndef WAVEFOLDER_SAMPLE_ASSERT_SVH
`define WAVEFOLDER_SAMPLE_ASSERT_SVH

// same-cycle implication
`define WVF_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WVF_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/wvf_pkg.sv
// ----------------------------------------------------------------------------
// wvf_pkg
// constants, register codes and sine table function of the wavefolder
// ----------------------------------------------------------------------------
`default_nettype none

package wvf_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOLDS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHAPE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIX   = 3'd4;

	// fold shapes
	localparam logic [1:0] SHAPE_SINE   = 2'd0;
	localparam logic [1:0] SHAPE_TRI    = 2'd1;
	localparam logic [1:0] SHAPE_MIRROR = 2'd2;
	localparam logic [1:0] SHAPE_ASYM   = 2'd3;

	// register ranges
	localparam int GAIN_W   = 14;
	localparam int GAIN_MIN = 256;
	localparam int GAIN_MAX = 12800;
	localparam int GAIN_RST = 1280;

	localparam int MAX_FOLDS = 10;
	localparam int FOLD_W    = 12;
	localparam int FOLD_N_W  = 4;
	localparam int FOLD_MIN  = 256;
	localparam int FOLD_MAX  = MAX_FOLDS * 256;
	localparam int FOLD_RST  = 512;

	localparam int BIAS_W   = 16;
	localparam int BIAS_LIM = 16384;

	localparam int MIX_W   = 16;
	localparam int MIX_ONE = 32768;

	// gain compensation 1/(1+0.1*gain) as 2560/(2560+gain)
	localparam int COMP_NUM  = 2560;
	localparam int COMP_D_W  = 14;
	localparam int MIX_SHIFT = 23;

	// sine table
	localparam int SINE_DEPTH = 1024;
	localparam int SINE_IDX_W = 10;
	localparam int SINE_W     = 16;

	typedef logic signed [SINE_W-1:0] sine_t;

	// quarter-wave polynomial, Q15
	function automatic sine_t sine_entry(input int unsigned k);
		longint r;
		longint fr;
		longint u;
		longint u2;
		longint t;
		logic [1:0] quad;
		r = (longint'(k) * 4 * 32768) / SINE_DEPTH;
		quad = 2'((r >>> 15) & 3);
		fr = r & 32767;
		u = quad[0] ? 32768 - fr : fr;
		u2 = (u * u) >>> 15;
		t = (2605 * u2) >>> 15;
		t = 21167 - t;
		t = (t * u2) >>> 15;
		t = 51472 - t;
		t = (t * u) >>> 15;
		if (t > 32767) begin
			t = 32767;
		end
		return quad[1] ? sine_t'(-t) : sine_t'(t);
	endfunction

endpackage

`default_nettype wire

### design/wvf_if.sv
// ----------------------------------------------------------------------------
// wvf interfaces
// sample input, sample output and configuration write channels
// ----------------------------------------------------------------------------
`default_nettype none

interface wvf_in_if #(parameter int SAMPLE_BITS = 16) ();
	logic valid;
	logic ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface wvf_out_if #(parameter int SAMPLE_BITS = 16) ();
	logic valid;
	logic ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

interface wvf_cfg_if import wvf_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/wvf_div.sv
// ----------------------------------------------------------------------------
// wvf_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wvf_div #(
	parameter int NW = 44,
	parameter int MW = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [MW-1:0] divisor,
	output logic          busy,
	output logic [NW-1:0] quotient
);

	localparam int CNT_W = $clog2(NW);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MW-1:0]    rem_q;
	logic [MW-1:0]    dsr_q;
	logic [NW-1:0]    quo_q;
	logic [MW:0]      trial;
	logic             fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CNT_W'(NW - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? MW'(trial - {1'b0, dsr_q}) : trial[MW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### design/wavefolder_sample.sv
// ----------------------------------------------------------------------------
// wavefolder_sample
// audio wavefolder: drive gain, one of four folders, gain compensation, mix
// ----------------------------------------------------------------------------
// usage
//   inp  : one signed sample word per handshake (valid and ready both high)
//   outp : one folded and mixed sample word for every input word, in order
//   cfg  : register writes, index 0 gain, 1 folds, 2 shape, 3 bias, 4 mix;
//          ready is always high, out-of-range values are clamped on write
// throughput
//   one word per cycle sustained while outp.ready is high and the dividers are
//   idle, through the 13-stage pipeline
// reset and configuration
//   reset empties the pipeline and loads the register defaults; after reset
//   and after every register write three serial dividers compute the fold
//   limits and the compensation reciprocal, one bit a cycle, and inp.ready
//   stays low until they are done
// stalls
//   every stage has its own valid bit and advances when its successor has
//   room, so a stalled receiver fills bubbles first and drops nothing
// ----------------------------------------------------------------------------
`default_nettype none

`include "wavefolder_sample_assert.svh"

module wavefolder_sample
	import wvf_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	wvf_in_if.sink           inp,
	wvf_out_if.source        outp,
	wvf_cfg_if.sink          cfg
);

	localparam int SB   = SAMPLE_BITS;
	localparam int NS   = 13;            // pipeline stages
	localparam int DW   = SB + 14;       // driven sample
	localparam int PW   = SB + 26;       // driven sample times folds
	localparam int RW   = SB + 17;       // triangle remainder
	localparam int MW   = SB + 16;       // mirror and folded values
	localparam int LW   = SB + 10;       // fold limits
	localparam int FMW  = SB + 14;       // folded magnitude
	localparam int K    = SB + 16;       // reciprocal fraction bits
	localparam int QW   = K + 12;        // divider width
	localparam int CW   = SB + 28;       // correction arithmetic
	localparam int WW   = SB + 15;       // wet sample
	localparam int DRW  = SB + 17;       // dry product
	localparam int WPW  = SB + 30;       // wet product
	localparam int AW   = SB + 31;       // mix sum
	localparam int YW   = AW - MIX_SHIFT;
	localparam longint HALF = 64'sd1 <<< (SB + 15);
	localparam logic signed [YW-1:0] Y_MAX = YW'((64'sd1 <<< (SB - 1)) - 1);
	localparam logic signed [YW-1:0] Y_MIN = YW'(-(64'sd1 <<< (SB - 1)));

	// ------------------------------------------------------------------
	// configuration registers, stored already clamped
	// ------------------------------------------------------------------
	logic [GAIN_W-1:0]        gain_q;
	logic [FOLD_W-1:0]        fold_q;
	logic [1:0]               shape_q;
	logic signed [BIAS_W-1:0] bias_q;
	logic [MIX_W-1:0]         mix_q;
	logic                     start_q;
	logic                     cfg_acc;
	logic [GAIN_W-1:0]        gain_in;
	logic [FOLD_W-1:0]        fold_in;
	logic signed [BIAS_W-1:0] bias_in;
	logic [MIX_W-1:0]         mix_in;

	assign cfg.ready = 1'b1;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign gain_in   = cfg.data[GAIN_W-1:0];
	assign fold_in   = cfg.data[FOLD_W-1:0];
	assign bias_in   = $signed(cfg.data[BIAS_W-1:0]);
	assign mix_in    = cfg.data[MIX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_W'(GAIN_RST);
			fold_q  <= FOLD_W'(FOLD_RST);
			shape_q <= SHAPE_SINE;
			bias_q  <= '0;
			mix_q   <= MIX_W'(MIX_ONE);
			start_q <= 1'b1;
		end else begin
			// every write restarts the limit and reciprocal computation
			start_q <= cfg_acc;
			if (cfg_acc) begin
				unique case (cfg.index)
					REG_GAIN: begin
						if (gain_in < GAIN_W'(GAIN_MIN)) gain_q <= GAIN_W'(GAIN_MIN);
						else if (gain_in > GAIN_W'(GAIN_MAX)) gain_q <= GAIN_W'(GAIN_MAX);
						else gain_q <= gain_in;
					end
					REG_FOLDS: begin
						if (fold_in < FOLD_W'(FOLD_MIN)) fold_q <= FOLD_W'(FOLD_MIN);
						else if (fold_in > FOLD_W'(FOLD_MAX)) fold_q <= FOLD_W'(FOLD_MAX);
						else fold_q <= fold_in;
					end
					REG_SHAPE: begin
						shape_q <= cfg.data[1:0];
					end
					REG_BIAS: begin
						if (bias_in > BIAS_W'(BIAS_LIM)) bias_q <= BIAS_W'(BIAS_LIM);
						else if (bias_in < -BIAS_W'(BIAS_LIM)) bias_q <= -BIAS_W'(BIAS_LIM);
						else bias_q <= bias_in;
					end
					REG_MIX: begin
						if (mix_in > MIX_W'(MIX_ONE)) mix_q <= MIX_W'(MIX_ONE);
						else mix_q <= mix_in;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// derived constants: fold limits and compensation reciprocal
	// ------------------------------------------------------------------
	logic signed [BIAS_W:0]   bias_up;
	logic signed [BIAS_W:0]   bias_dn;
	logic [QW-1:0]            hi_dvd;
	logic [QW-1:0]            lo_dvd;
	logic [QW-1:0]            rc_dvd;
	logic [COMP_D_W-1:0]      comp_d;
	logic [COMP_D_W-1:0]      fold_dsr;
	logic [QW-1:0]            hi_quo;
	logic [QW-1:0]            lo_quo;
	logic [QW-1:0]            rc_quo;
	logic [2:0]               div_busy_v;
	logic                     div_busy;
	logic signed [LW-1:0]     hi_lim;
	logic signed [LW-1:0]     lo_lim;
	logic [K-1:0]             recip;
	logic signed [MW-1:0]     offs;
	logic [FOLD_N_W-1:0]      nfold;
	logic                     mirror_sel;

	assign bias_up  = (BIAS_W + 1)'(BIAS_LIM) + (BIAS_W + 1)'(bias_q);
	assign bias_dn  = (BIAS_W + 1)'(BIAS_LIM) - (BIAS_W + 1)'(bias_q);
	// asymmetric: (1 +/- bias) * 256 / folds; mirror: 2^(SB+15) / folds
	assign hi_dvd   = (shape_q == SHAPE_ASYM) ? (QW'($unsigned(bias_up)) << (SB + 1))
		: (QW'(1) << (SB + 15));
	assign lo_dvd   = (shape_q == SHAPE_ASYM) ? (QW'($unsigned(bias_dn)) << (SB + 1))
		: (QW'(1) << (SB + 15));
	assign rc_dvd   = QW'(COMP_NUM) << K;
	assign comp_d   = COMP_D_W'(COMP_NUM) + COMP_D_W'(gain_q);
	assign fold_dsr = COMP_D_W'(fold_q);

	wvf_div #(.NW(QW), .MW(COMP_D_W)) u_div_hi (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (hi_dvd),
		.divisor  (fold_dsr),
		.busy     (div_busy_v[0]),
		.quotient (hi_quo)
	);

	wvf_div #(.NW(QW), .MW(COMP_D_W)) u_div_lo (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (lo_dvd),
		.divisor  (fold_dsr),
		.busy     (div_busy_v[1]),
		.quotient (lo_quo)
	);

	wvf_div #(.NW(QW), .MW(COMP_D_W)) u_div_rc (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (rc_dvd),
		.divisor  (comp_d),
		.busy     (div_busy_v[2]),
		.quotient (rc_quo)
	);

	assign div_busy   = |div_busy_v;
	assign hi_lim     = $signed({1'b0, hi_quo[LW-2:0]});
	assign lo_lim     = -$signed({1'b0, lo_quo[LW-2:0]});
	assign recip      = rc_quo[K-1:0];
	assign offs       = (shape_q == SHAPE_ASYM) ? (MW'(bias_q) <<< (SB - 7)) : '0;
	assign nfold      = fold_q[FOLD_W-1:8];
	assign mirror_sel = (shape_q == SHAPE_MIRROR) || (shape_q == SHAPE_ASYM);

	// one mirror pass about the upper and lower limit
	function automatic logic signed [MW-1:0] mstep(
		input logic signed [MW-1:0] x,
		input logic signed [LW-1:0] hi,
		input logic signed [LW-1:0] lo,
		input logic                 on
	);
		logic signed [MW-1:0] h;
		logic signed [MW-1:0] l;
		h = MW'(hi);
		l = MW'(lo);
		mstep = x;
		if (on) begin
			if (x > h) mstep = (h <<< 1) - x;
			else if (x < l) mstep = (l <<< 1) - x;
		end
	endfunction

	// ------------------------------------------------------------------
	// sine table
	// ------------------------------------------------------------------
	sine_t sine_rom [SINE_DEPTH];

	for (genvar k = 0; k < SINE_DEPTH; k++) begin : g_rom
		assign sine_rom[k] = sine_entry(k);
	end

	// ------------------------------------------------------------------
	// stage valid bits and per-stage advance
	// ------------------------------------------------------------------
	logic [NS:1] vld_s;
	logic [NS:1] adv;
	logic        cfg_ok;
	logic        in_take;

	assign cfg_ok    = !start_q && !div_busy;
	assign inp.ready = adv[1] && cfg_ok;
	assign in_take   = inp.valid && cfg_ok;
	assign adv[NS]   = !vld_s[NS] || outp.ready;

	for (genvar i = 1; i < NS; i++) begin : g_adv
		assign adv[i] = !vld_s[i] || adv[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[1]) vld_s[1] <= in_take;
			for (int i = 2; i <= NS; i++) begin
				if (adv[i]) vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// datapath
	// ------------------------------------------------------------------
	logic signed [SB-1:0]  x_s1, x_s2, x_s3, x_s4, x_s5, x_s6, x_s7, x_s8, x_s9,
		x_s10, x_s11;
	logic signed [DW-1:0]  d_s1, d_s2;
	logic signed [PW-1:0]  p_s2;
	logic signed [MW-1:0]  m_s3, m_s4, m_s5, m_s6, m_s7, m_s8;
	logic signed [MW-1:0]  sin_s3;
	logic signed [RW-1:0]  r_s3;
	logic signed [MW-1:0]  alt_s4, alt_s5, alt_s6, alt_s7, alt_s8;
	logic [FMW-1:0]        fmag_s9, fmag_s10;
	logic                  fneg_s9, fneg_s10;
	logic [FMW-1:0]        qe_s10;
	logic signed [WW-1:0]  wet_s11;
	logic signed [DRW-1:0] dry_s12;
	logic signed [WPW-1:0] wp_s12;
	logic signed [SB-1:0]  y_s13;

	// stage 1: drive gain
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			x_s1 <= inp.sample_in;
			d_s1 <= DW'(inp.sample_in * $signed({1'b0, gain_q}));
		end
	end

	// stage 2: phase, driven sample times folds
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			x_s2 <= x_s1;
			d_s2 <= d_s1;
			p_s2 <= PW'(d_s1 * $signed({1'b0, fold_q}));
		end
	end

	// stage 3: sine lookup, triangle remainder, mirror start
	logic signed [PW:0]         tri_v;
	logic [PW:0]                tri_mag;
	logic [RW-2:0]              tri_low;
	logic [SINE_IDX_W-1:0]      sine_idx;

	assign tri_v    = (PW + 1)'(p_s2) + (PW + 1)'(HALF);
	assign tri_mag  = tri_v[PW] ? $unsigned(-tri_v) : $unsigned(tri_v);
	assign tri_low  = tri_mag[RW-2:0];
	assign sine_idx = p_s2[SB+15 -: SINE_IDX_W];

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			x_s3   <= x_s2;
			m_s3   <= MW'(d_s2) + offs;
			sin_s3 <= MW'(sine_rom[sine_idx]) <<< (SB - 8);
			// fmod keeps the sign of the dividend
			r_s3   <= tri_v[PW] ? -$signed({1'b0, tri_low}) : $signed({1'b0, tri_low});
		end
	end

	// stage 4: triangle finish, mirror passes 0 and 1
	logic signed [SB+17:0] tri_t;
	logic signed [SB+17:0] tri_ph;
	logic signed [SB+18:0] tri_e;

	assign tri_t  = (SB + 18)'(r_s3) - (SB + 18)'(HALF);
	assign tri_ph = (tri_t < 0) ? -tri_t : tri_t;
	assign tri_e  = ((SB + 19)'(tri_ph) <<< 1) - (SB + 19)'(HALF);

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			x_s4   <= x_s3;
			alt_s4 <= (shape_q == SHAPE_SINE) ? sin_s3 : MW'(tri_e >>> 8);
			m_s4   <= mstep(mstep(m_s3, hi_lim, lo_lim, nfold > FOLD_N_W'(0)),
				hi_lim, lo_lim, nfold > FOLD_N_W'(1));
		end
	end

	// stages 5 to 8: remaining mirror passes
	always_ff @(posedge clk) begin
		if (adv[5]) begin
			x_s5   <= x_s4;
			alt_s5 <= alt_s4;
			m_s5   <= mstep(mstep(m_s4, hi_lim, lo_lim, nfold > FOLD_N_W'(2)),
				hi_lim, lo_lim, nfold > FOLD_N_W'(3));
		end
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			x_s6   <= x_s5;
			alt_s6 <= alt_s5;
			m_s6   <= mstep(mstep(m_s5, hi_lim, lo_lim, nfold > FOLD_N_W'(4)),
				hi_lim, lo_lim, nfold > FOLD_N_W'(5));
		end
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			x_s7   <= x_s6;
			alt_s7 <= alt_s6;
			m_s7   <= mstep(mstep(m_s6, hi_lim, lo_lim, nfold > FOLD_N_W'(6)),
				hi_lim, lo_lim, nfold > FOLD_N_W'(7));
		end
	end

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			x_s8   <= x_s7;
			alt_s8 <= alt_s7;
			m_s8   <= mstep(mstep(m_s7, hi_lim, lo_lim, nfold > FOLD_N_W'(8)),
				hi_lim, lo_lim, nfold > FOLD_N_W'(9));
		end
	end

	// stage 9: pick folder, split sign and magnitude
	logic signed [MW-1:0] fold_v;

	assign fold_v = mirror_sel ? (m_s8 - offs) : alt_s8;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			x_s9    <= x_s8;
			fneg_s9 <= fold_v < 0;
			fmag_s9 <= FMW'((fold_v < 0) ? -fold_v : fold_v);
		end
	end

	// stage 10: quotient estimate by reciprocal
	logic [FMW+K-1:0] rc_prod;

	assign rc_prod = fmag_s9 * recip;

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			x_s10    <= x_s9;
			fneg_s10 <= fneg_s9;
			fmag_s10 <= fmag_s9;
			qe_s10   <= FMW'(rc_prod >> K);
		end
	end

	// stage 11: correct estimate by at most one, restore sign
	logic [CW-1:0]  cmp_num;
	logic [CW-1:0]  cmp_qd;
	logic [CW-1:0]  cmp_rem;
	logic [FMW-1:0] q_fix;

	assign cmp_num = (CW'(fmag_s10) << 11) + (CW'(fmag_s10) << 9);
	assign cmp_qd  = CW'(qe_s10) * CW'(comp_d);
	assign cmp_rem = cmp_num - cmp_qd;
	assign q_fix   = (cmp_rem >= CW'(comp_d)) ? qe_s10 + 1'b1 : qe_s10;

	always_ff @(posedge clk) begin
		if (adv[11]) begin
			x_s11    <= x_s10;
			wet_s11  <= fneg_s10 ? -$signed(WW'(q_fix)) : $signed(WW'(q_fix));
		end
	end

	// stage 12: dry and wet weights
	logic signed [MIX_W:0] dry_w;
	logic signed [MIX_W:0] wet_w;

	assign dry_w = $signed({1'b0, MIX_W'(MIX_ONE) - mix_q});
	assign wet_w = $signed({1'b0, mix_q});

	always_ff @(posedge clk) begin
		if (adv[12]) begin
			dry_s12 <= DRW'(x_s11) * DRW'(dry_w);
			wp_s12  <= WPW'(wet_s11) * WPW'(wet_w);
		end
	end

	// stage 13: sum, floor shift, saturate
	logic signed [AW-1:0] mix_acc;
	logic signed [YW-1:0] mix_y;

	assign mix_acc = (AW'(dry_s12) <<< 8) + AW'(wp_s12);
	assign mix_y   = YW'(mix_acc >>> MIX_SHIFT);

	always_ff @(posedge clk) begin
		if (adv[13]) begin
			if (mix_y > Y_MAX) y_s13 <= SB'(Y_MAX);
			else if (mix_y < Y_MIN) y_s13 <= SB'(Y_MIN);
			else y_s13 <= SB'(mix_y);
		end
	end

	assign outp.valid      = vld_s[NS];
	assign outp.sample_out = y_s13;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`WVF_ASSERT_NEXT(a_take_enters, clk, arst_n, inp.valid && inp.ready, vld_s[1],
		"accepted word did not enter stage 1")
	`WVF_ASSERT_NOW(a_cfg_recompute, clk, arst_n,
		$past(arst_n, 2) && $past(cfg.valid && cfg.ready, 2), div_busy,
		"register write did not start the divider")
	`WVF_ASSERT_NOW(a_fill_when_ready, clk, arst_n, $rose(vld_s[1]),
		$past(!start_q && !div_busy), "word entered while limits were stale")

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// wavefolder_sample testbench
// drives random and edge-case audio words through every fold shape under a
// range of register settings, predicts each folded word in fixed point and
// compares it with the output stream in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import wvf_pkg::*;

	localparam int SB = 16;
	localparam int WFR = SB + 7;            // fractional bits of the driven value
	localparam logic [CFG_IDX_W-1:0] REG_LAST = {CFG_IDX_W{1'b1}};

	typedef enum logic [1:0] {W_SAMPLE, W_CFG, W_DRAIN} word_kind_t;

	typedef struct {
		word_kind_t kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		logic signed [SB-1:0] smp;
	} stim_word_t;

	logic clk;
	logic arst_n;

	wvf_in_if #(.SAMPLE_BITS(SB)) inp_if ();
	wvf_out_if #(.SAMPLE_BITS(SB)) outp_if ();
	wvf_cfg_if cfg_if ();

	wavefolder_sample #(.SAMPLE_BITS(SB)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.inp(inp_if.sink),
		.outp(outp_if.source),
		.cfg(cfg_if.sink)
	);

	// stimulus and expectations
	stim_word_t pending_words[$];
	logic signed [SB-1:0] expected_samples[$];

	// shadow copy of the register file, raw as written
	logic [GAIN_W-1:0] sh_gain;
	logic [FOLD_W-1:0] sh_folds;
	logic [1:0] sh_shape;
	logic [BIAS_W-1:0] sh_bias;
	logic [MIX_W-1:0] sh_mix;

	int sine_tab[SINE_DEPTH];

	int errors;
	int words_sent;
	int words_checked;
	int cfg_writes;
	int shape_hits[4];
	int unsigned cyc;
	int quiet_cycles;

	// clock and cycle counter
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// long stretches with no idling on either side
	function automatic bit steady_phase();
		return (cyc % 3000) >= 2200;
	endfunction

	function automatic bit idle_roll();
		return !steady_phase() && ($urandom_range(0, 99) < 22);
	endfunction

	// quarter-wave polynomial sine, Q15, full period over the table
	function automatic int sine_value(input int k);
		longint r;
		longint fr;
		longint u;
		longint u2;
		longint t;
		int q;
		r = (longint'(k) * 4 * 32768) / SINE_DEPTH;
		q = int'((r >> 15) & 3);
		fr = r & 32767;
		u = q[0] ? 32768 - fr : fr;
		u2 = (u * u) >> 15;
		t = (2605 * u2) >> 15;
		t = 21167 - t;
		t = (t * u2) >> 15;
		t = 51472 - t;
		t = (t * u) >> 15;
		if (t > 32767) begin
			t = 32767;
		end
		return q[1] ? int'(-t) : int'(t);
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// reflect about the upper and lower limits, once per whole fold
	function automatic longint mirror_fold(input longint x, input longint hi,
			input longint lo, input longint n);
		for (int i = 0; i < MAX_FOLDS; i++) begin
			if (i >= n) begin
				break;
			end
			if (x > hi) begin
				x = 2 * hi - x;
			end else if (x < lo) begin
				x = 2 * lo - x;
			end
		end
		return x;
	endfunction

	// folded, compensated and mixed output word for one input word
	function automatic logic signed [SB-1:0] fold_and_mix(input logic signed [SB-1:0] smp);
		longint x;
		longint g;
		longint f;
		longint b;
		longint m;
		longint d;
		longint folded;
		longint wet;
		longint acc;
		longint y;
		longint half;
		longint pmask;
		longint v;
		longint r;
		longint ph;
		longint th;
		longint bw;
		longint one;
		longint pos;
		longint neg;
		longint pm;
		longint idx;
		x = longint'(smp);
		g = clamp(longint'(sh_gain), GAIN_MIN, GAIN_MAX);
		f = clamp(longint'(sh_folds), FOLD_MIN, FOLD_MAX);
		b = clamp(longint'($signed(sh_bias)), -BIAS_LIM, BIAS_LIM);
		m = clamp(longint'(sh_mix), 0, MIX_ONE);
		half = longint'(1) <<< (WFR + 8);
		pmask = (longint'(1) <<< (WFR + 9)) - 1;
		d = x * g;
		case (sh_shape)
			SHAPE_TRI: begin
				// fmod keeps the sign of the dividend
				v = d * f + half;
				r = v >= 0 ? (v & pmask) : -((-v) & pmask);
				ph = r - half;
				if (ph < 0) begin
					ph = -ph;
				end
				folded = (2 * ph - half) >>> 8;
			end
			SHAPE_MIRROR: begin
				th = half / f;
				folded = mirror_fold(d, th, -th, f >> 8);
			end
			SHAPE_ASYM: begin
				bw = b * (longint'(1) <<< (WFR - 14));
				one = longint'(1) <<< WFR;
				pos = ((one + bw) * 256) / f;
				neg = ((bw - one) * 256) / f;
				folded = mirror_fold(d + bw, pos, neg, f >> 8) - bw;
			end
			default: begin
				// phase wraps once per period, top bits select the table entry
				pm = (d * f) & pmask;
				idx = (pm * SINE_DEPTH) >> (WFR + 9);
				if (idx >= SINE_DEPTH) begin
					idx = SINE_DEPTH - 1;
				end
				folded = longint'(sine_tab[idx]) * (longint'(1) <<< (WFR - 15));
			end
		endcase
		wet = (folded * COMP_NUM) / (COMP_NUM + g);
		acc = x * (MIX_ONE - m) * 256 + wet * m;
		y = acc >>> MIX_SHIFT;
		y = clamp(y, -(longint'(1) <<< (SB - 1)), (longint'(1) <<< (SB - 1)) - 1);
		return y[SB-1:0];
	endfunction

	// driver: presents queued words, updates the shadow registers and queues
	// the expected output word at each accepted handshake
	always @(posedge clk or negedge arst_n) begin
		logic take_in;
		logic take_cfg;
		logic nxt_in_valid;
		logic nxt_cfg_valid;
		stim_word_t w;
		if (!arst_n) begin
			inp_if.valid <= 1'b0;
			inp_if.sample_in <= '0;
			cfg_if.valid <= 1'b0;
			cfg_if.index <= '0;
			cfg_if.data <= '0;
			quiet_cycles <= 0;
		end else begin
			take_in = inp_if.valid && inp_if.ready;
			take_cfg = cfg_if.valid && cfg_if.ready;
			if (take_cfg) begin
				cfg_writes++;
				case (cfg_if.index)
					REG_GAIN: sh_gain = cfg_if.data[GAIN_W-1:0];
					REG_FOLDS: sh_folds = cfg_if.data[FOLD_W-1:0];
					REG_SHAPE: sh_shape = cfg_if.data[1:0];
					REG_BIAS: sh_bias = cfg_if.data;
					REG_MIX: sh_mix = cfg_if.data;
					default: ;  // unmapped index, no effect
				endcase
			end
			if (take_in) begin
				expected_samples.push_back(fold_and_mix(inp_if.sample_in));
				shape_hits[sh_shape]++;
				words_sent++;
			end
			// quiet count lets the pipeline settle before a register write
			quiet_cycles <= (expected_samples.size() == 0 && !inp_if.valid) ?
				quiet_cycles + 1 : 0;
			nxt_in_valid = inp_if.valid && !take_in;
			nxt_cfg_valid = cfg_if.valid && !take_cfg;
			if (!nxt_in_valid && !nxt_cfg_valid && pending_words.size() != 0) begin
				w = pending_words[0];
				case (w.kind)
					W_SAMPLE: begin
						if (!idle_roll()) begin
							void'(pending_words.pop_front());
							nxt_in_valid = 1'b1;
							inp_if.sample_in <= w.smp;
						end
					end
					W_CFG: begin
						if (!take_in && expected_samples.size() == 0 && quiet_cycles >= 16) begin
							void'(pending_words.pop_front());
							nxt_cfg_valid = 1'b1;
							cfg_if.index <= w.idx;
							cfg_if.data <= w.data;
						end
					end
					default: begin
						// hold off until the output side has caught up
						if (!take_in && expected_samples.size() == 0) begin
							void'(pending_words.pop_front());
						end
					end
				endcase
			end
			inp_if.valid <= nxt_in_valid;
			cfg_if.valid <= nxt_cfg_valid;
		end
	end

	// monitor: random back-pressure and in-order comparison
	always @(posedge clk or negedge arst_n) begin
		logic signed [SB-1:0] want;
		if (!arst_n) begin
			outp_if.ready <= 1'b0;
		end else begin
			if (outp_if.valid && outp_if.ready) begin
				if (expected_samples.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("unexpected output word %0d", outp_if.sample_out);
					end
				end else begin
					want = expected_samples.pop_front();
					words_checked++;
					if (outp_if.sample_out !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("sample_out mismatch: expected %0d, got %0d (word %0d)",
								want, outp_if.sample_out, words_checked);
						end
					end
				end
			end
			outp_if.ready <= !idle_roll();
		end
	end

	task automatic add_sample(input logic signed [SB-1:0] s);
		stim_word_t w;
		w.kind = W_SAMPLE;
		w.idx = '0;
		w.data = '0;
		w.smp = s;
		pending_words.push_back(w);
	endtask

	task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		stim_word_t w;
		w.kind = W_CFG;
		w.idx = idx;
		w.data = v;
		w.smp = '0;
		pending_words.push_back(w);
	endtask

	task automatic add_drain();
		stim_word_t w;
		w.kind = W_DRAIN;
		w.idx = '0;
		w.data = '0;
		w.smp = '0;
		pending_words.push_back(w);
	endtask

	// mostly in-range values, with the range ends and out-of-range raw values
	function automatic logic [CFG_DATA_W-1:0] pick_value(input int lo, input int hi);
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			return CFG_DATA_W'(lo);
		end else if (sel == 1) begin
			return CFG_DATA_W'(hi);
		end else if (sel == 2) begin
			return CFG_DATA_W'($urandom_range(0, 65535));
		end
		return CFG_DATA_W'($urandom_range(0, hi - lo) + lo);
	endfunction

	function automatic logic signed [SB-1:0] pick_sample();
		int sel;
		sel = $urandom_range(0, 19);
		case (sel)
			0: return SB'(-(1 <<< (SB - 1)));
			1: return SB'((1 <<< (SB - 1)) - 1);
			2: return SB'(int'($urandom_range(0, 15)) - 8);
			3: return SB'(int'($urandom_range(0, 1023)) - 512);
			default: return SB'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		int n_rand;
		logic signed [BIAS_W-1:0] bias_v;
		arst_n = 1'b0;
		errors = 0;
		words_sent = 0;
		words_checked = 0;
		cfg_writes = 0;
		cyc = 0;
		foreach (shape_hits[i]) begin
			shape_hits[i] = 0;
		end
		inp_if.valid = 1'b0;
		inp_if.sample_in = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		outp_if.ready = 1'b0;
		for (int k = 0; k < SINE_DEPTH; k++) begin
			sine_tab[k] = sine_value(k);
		end
		// reset values of the register file
		sh_gain = GAIN_W'(GAIN_RST);
		sh_folds = FOLD_W'(FOLD_RST);
		sh_shape = SHAPE_SINE;
		sh_bias = '0;
		sh_mix = MIX_W'(MIX_ONE);

		// directed: reset settings, field extremes, alternating-bit patterns
		add_sample(SB'(-(1 <<< (SB - 1))));
		add_sample(SB'((1 <<< (SB - 1)) - 1));
		add_sample('0);
		add_sample(SB'(-1));
		add_sample(SB'(1));
		add_sample(16'h5555);
		add_sample(16'hAAAA);
		// every shape with extremes of gain and folds, full wet
		for (int s = 0; s < 4; s++) begin
			add_write(REG_SHAPE, CFG_DATA_W'(s));
			add_write(REG_GAIN, (s % 2) ? CFG_DATA_W'(GAIN_MAX) : CFG_DATA_W'(GAIN_MIN));
			add_write(REG_FOLDS, (s < 2) ? CFG_DATA_W'(FOLD_MAX) : CFG_DATA_W'(FOLD_MIN));
			add_write(REG_BIAS, (s == 3) ? CFG_DATA_W'(BIAS_LIM) : '0);
			add_sample(SB'(-(1 <<< (SB - 1))));
			add_sample(SB'((1 <<< (SB - 1)) - 1));
			add_sample(SB'(1234));
		end
		// out-of-range register values get clamped, unmapped indexes ignored
		add_write(REG_GAIN, '1);
		add_write(REG_FOLDS, '0);
		add_write(REG_BIAS, 16'h8000);
		add_write(REG_MIX, '1);
		for (int i = REG_MIX + 1; i <= REG_LAST; i++) begin
			add_write(CFG_IDX_W'(i), '1);
		end
		add_sample(SB'(-(1 <<< (SB - 1))));
		add_sample(SB'(20000));
		add_write(REG_GAIN, '0);
		add_write(REG_FOLDS, 16'h0FFF);
		add_write(REG_BIAS, 16'h7FFF);
		add_write(REG_MIX, '0);
		add_sample(SB'(-20000));

		// random phases, each with a fresh register setting
		n_rand = 0;
		for (int ph = 0; n_rand < 500; ph++) begin
			add_write(REG_SHAPE, CFG_DATA_W'(ph % 4));
			add_write(REG_GAIN, pick_value(GAIN_MIN, GAIN_MAX));
			add_write(REG_FOLDS, pick_value(FOLD_MIN, FOLD_MAX));
			bias_v = BIAS_W'($urandom_range(0, 2 * BIAS_LIM)) - BIAS_W'(BIAS_LIM);
			add_write(REG_BIAS, ($urandom_range(0, 4) == 0) ? pick_value(0, 65535) : bias_v);
			add_write(REG_MIX, pick_value(0, MIX_ONE));
			for (int i = 0; i < 40; i++) begin
				add_sample(pick_sample());
				n_rand++;
				// sender holds off until the pipeline has emptied
				if (i == 20 && ph % 3 == 0) begin
					add_drain();
				end
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() != 0 || inp_if.valid || cfg_if.valid) begin
			@(posedge clk);
		end
		while (expected_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);

		$display("checked %0d of %0d words over %0d register writes", words_checked,
			words_sent, cfg_writes);
		$display("words per shape: sine %0d, triangle %0d, mirror %0d, asymmetric %0d",
			shape_hits[SHAPE_SINE], shape_hits[SHAPE_TRI], shape_hits[SHAPE_MIRROR],
			shape_hits[SHAPE_ASYM]);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
